### sv/ftfr_pkg.sv
package ftfr_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 32;
   localparam int CHAR_WIDTH = 7;

   localparam logic [7:0] BYTE_TERM = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_REBOOT = 8'h88;
   localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
   localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;

   localparam logic [1:0] TERM_LAST = 2'd2;
   localparam logic [1:0] ZERO_FULL = 2'd3;

   localparam logic EVENT_CHAR = 1'b0;
   localparam logic EVENT_RESYNC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EVENT
   } state_type;

   typedef struct packed {
      logic take;
      logic drain_first;
      logic drain_next;
      logic frame_clear;
      logic event_sel;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic has_chars;
      logic boot;
      logic last;
   } status_type;

endpackage

### sv/ftfr_ram.sv
module ftfr_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 32
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ftfr_datapath.sv
module ftfr_datapath
   import ftfr_pkg::*;
   #(
      parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  cmd_type               cmd,
      output status_type            status,
      input  logic [7:0]            rx_byte,
      output logic                  event_kind,
      output logic [CHAR_WIDTH-1:0] char_out,
      output logic                  last_of_frame
   );

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [AW-1:0] MAX_COUNT = AW'(BUFFER_DEPTH - 1);

   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [1:0]    term_ff, term_in;
   logic [1:0]    zero_ff, zero_in;
   logic          marker_ff, marker_in;

   logic                  is_term;
   logic                  printable;
   logic                  wr_en;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [CHAR_WIDTH-1:0] rd_data;

   assign is_term = (rx_byte == BYTE_TERM);
   assign printable = (rx_byte >= BYTE_PRINT_LO) && (rx_byte <= BYTE_PRINT_HI);
   assign wr_en = cmd.take && !is_term && printable && (count_ff < MAX_COUNT);
   assign rd_en = cmd.drain_first || cmd.drain_next;
   assign rd_addr = cmd.drain_first ? '0 : idx_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      term_in = term_ff;
      zero_in = zero_ff;
      marker_in = marker_ff;
      idx_in = rd_en ? rd_addr : idx_ff;
      if (cmd.take) begin
         if (is_term) begin
            if (term_ff == TERM_LAST) begin
               term_in = '0;
               zero_in = '0;
               marker_in = 1'b0;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end else begin
            term_in = '0;
            if (count_ff == '0) begin
               if (rx_byte == BYTE_ZERO && zero_ff != ZERO_FULL) begin
                  zero_in = zero_ff + 1'b1;
               end else if (rx_byte == BYTE_REBOOT) begin
                  marker_in = 1'b1;
               end else begin
                  zero_in = '0;
                  marker_in = 1'b0;
               end
            end
            if (wr_en) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (cmd.frame_clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         term_ff <= '0;
         zero_ff <= '0;
         marker_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         term_ff <= term_in;
         zero_ff <= zero_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   ftfr_ram #(
      .WIDTH (CHAR_WIDTH),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (rx_byte[CHAR_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.frame_end = is_term && (term_ff == TERM_LAST);
   assign status.has_chars = (count_ff != '0);
   assign status.boot = (zero_ff == ZERO_FULL) || marker_ff;
   assign status.last = (idx_ff == count_ff - 1'b1);

   assign event_kind = cmd.event_sel ? EVENT_RESYNC : EVENT_CHAR;
   assign char_out = cmd.event_sel ? '0 : rd_data;
   assign last_of_frame = cmd.event_sel || status.last;

endmodule

### sv/ftfr_ctrl.sv
module ftfr_ctrl
   import ftfr_pkg::*;
   (
      input  logic       clock,
      input  logic       reset,
      input  logic       req_valid,
      output logic       req_stall,
      output logic       rsp_valid,
      input  logic       rsp_stall,
      input  status_type status,
      output cmd_type    cmd
   );

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.frame_end) begin
                  if (status.has_chars) begin
                     cmd.drain_first = 1'b1;
                     state_in = ST_DRAIN;
                  end else if (status.boot) begin
                     state_in = ST_EVENT;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!rsp_stall) begin
               if (status.last) begin
                  cmd.frame_clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.drain_next = 1'b1;
               end
            end
         end
         ST_EVENT: begin
            cmd.event_sel = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DRAIN) || (state_ff == ST_EVENT);

endmodule

### sv/ff_terminated_frame_receiver.sv
// A frame-end byte shows its first result in the cycle after its transfer.
// Throughput: one byte per cycle while no frame ends; a frame end holds the input
// while the stored characters (or a resync event) are sent, paced by the
// single read port of the character store and by rsp_stall.
// Reset: synchronous, active high; clears all frame tracking, the store is not cleared.
module ff_terminated_frame_receiver
   import ftfr_pkg::*;
   #(
      parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  req_valid,
      output logic                  req_stall,
      input  logic [7:0]            req_rx_byte,
      output logic                  rsp_valid,
      input  logic                  rsp_stall,
      output logic                  rsp_event_kind,
      output logic [CHAR_WIDTH-1:0] rsp_char_out,
      output logic                  rsp_last_of_frame
   );

   cmd_type    cmd;
   status_type status;

   ftfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ftfr_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .rx_byte       (req_rx_byte),
      .event_kind    (rsp_event_kind),
      .char_out      (rsp_char_out),
      .last_of_frame (rsp_last_of_frame)
   );

endmodule

### bench/frame_scoreboard_pkg.sv
package frame_scoreboard_pkg;

   import ftfr_pkg::*;

   typedef struct packed {
      logic                  kind;
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } frame_result_type;

   class frame_scoreboard;

      logic [CHAR_WIDTH-1:0] chars [BUFFER_DEPTH_DEFAULT];
      int unsigned           char_count;
      logic [1:0]            ff_run;
      logic [1:0]            zero_run;
      logic                  marker_seen;
      frame_result_type      due_q [$];
      int                    errors;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         char_count = 0;
         ff_run = 2'd0;
         zero_run = 2'd0;
         marker_seen = 1'b0;
      endfunction

      function void note_byte(logic [7:0] b);
         frame_result_type r;
         if (b == BYTE_TERM) begin
            if (ff_run == TERM_LAST) begin
               if (char_count > 0) begin
                  for (int i = 0; i < char_count; i++) begin
                     r.kind = EVENT_CHAR;
                     r.ch = chars[i];
                     r.last = (i == char_count - 1);
                     due_q.push_back(r);
                  end
               end else if (zero_run == ZERO_FULL || marker_seen) begin
                  r.kind = EVENT_RESYNC;
                  r.ch = '0;
                  r.last = 1'b1;
                  due_q.push_back(r);
               end
               clear_frame();
            end else begin
               ff_run = ff_run + 2'd1;
            end
            return;
         end
         ff_run = 2'd0;
         // boot tracking only while nothing is stored
         if (char_count == 0) begin
            if (b == BYTE_ZERO && zero_run != ZERO_FULL) begin
               zero_run = zero_run + 2'd1;
            end else if (b == BYTE_REBOOT) begin
               marker_seen = 1'b1;
            end else begin
               zero_run = 2'd0;
               marker_seen = 1'b0;
            end
         end
         if (b >= BYTE_PRINT_LO && b <= BYTE_PRINT_HI &&
             char_count < BUFFER_DEPTH_DEFAULT - 1) begin
            chars[char_count] = b[CHAR_WIDTH-1:0];
            char_count++;
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected result: kind %0d char %h last %0d",
                     $time, got.kind, got.ch, got.last);
            errors++;
            return;
         end
         want = due_q.pop_front();
         if (got.kind !== want.kind) begin
            $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
         end
         if (got.ch !== want.ch) begin
            $display("%0t: char_out expected %h actual %h", $time, want.ch, got.ch);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_of_frame expected %0d actual %0d",
                     $time, want.last, got.last);
            errors++;
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction

   endclass

endpackage

### bench/tb_ff_terminated_frame_receiver.sv
module tb_ff_terminated_frame_receiver;

   import ftfr_pkg::*;
   import frame_scoreboard_pkg::*;

   localparam int HANG_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 240;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_stall = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_event_kind;
   logic [CHAR_WIDTH-1:0] rsp_char_out;
   logic                  rsp_last_of_frame;

   frame_scoreboard sb = new();

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles = 0;
   int bytes_sent = 0;
   int quiet_cycles = 0;

   ff_terminated_frame_receiver uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_char_out      (rsp_char_out),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver side: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      frame_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_event_kind;
         got.ch = rsp_char_out;
         got.last = rsp_last_of_frame;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("tb_ff_terminated_frame_receiver NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_terminator();
      repeat (3) send_byte(BYTE_TERM);
   endtask

   function automatic logic [7:0] printable();
      return 8'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI));
   endfunction

   task automatic send_random_frame();
      int sel;
      int n;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2, 3, 4: begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            repeat (n) begin
               if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
               else send_byte(printable());
            end
            send_terminator();
         end
         5: begin
            repeat (3) send_byte(BYTE_ZERO);
            n = $urandom_range(0, 2);
            repeat (n) send_byte($urandom_range(0, 1) ? BYTE_ZERO : BYTE_REBOOT);
            send_terminator();
         end
         6: begin
            n = $urandom_range(0, 3);
            repeat (n) send_byte($urandom_range(0, 1) ? BYTE_ZERO : 8'($urandom_range(0, 255)));
            send_byte(BYTE_REBOOT);
            if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)));
            send_terminator();
         end
         7: begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
         end
         8: begin
            // broken terminator inside a frame
            send_byte(printable());
            n = $urandom_range(1, 2);
            repeat (n) send_byte(BYTE_TERM);
            send_byte(printable());
            send_terminator();
         end
         default: send_terminator();
      endcase
   endtask

   initial begin
      int phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // printable extremes, broken terminator, character frame
      send_byte(BYTE_PRINT_LO);
      send_byte(BYTE_PRINT_HI);
      send_byte(BYTE_TERM);
      send_byte(BYTE_TERM);
      send_byte(8'h41);
      send_terminator();
      // leading zeros -> resync
      repeat (3) send_byte(BYTE_ZERO);
      send_terminator();
      // reboot marker -> resync
      send_byte(BYTE_ZERO);
      send_byte(BYTE_REBOOT);
      send_terminator();
      // fourth zero clears boot tracking, non-printables dropped -> nothing
      repeat (4) send_byte(BYTE_ZERO);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_terminator();

      // long receiver hold-off against a full store
      hold_cycles = HOLD_OFF_CYCLES;
      repeat (BUFFER_DEPTH_DEFAULT + 2) send_byte(printable());
      send_terminator();
      send_byte(printable());
      send_terminator();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_ITEMS / 4) send_random_frame();
      end

      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_ff_terminated_frame_receiver OK");
      end else begin
         $display("tb_ff_terminated_frame_receiver NOT OK");
      end
      $finish;
   end

endmodule

### files.f
sv/ftfr_pkg.sv
sv/ftfr_ram.sv
sv/ftfr_datapath.sv
sv/ftfr_ctrl.sv
sv/ff_terminated_frame_receiver.sv
bench/frame_scoreboard_pkg.sv
bench/tb_ff_terminated_frame_receiver.sv
